[src/tts_pkg.sv]
package tts_pkg;

	// Source image size bounds and register reset value
	localparam int unsigned DIM_W      = 11;
	localparam int unsigned CNT_W      = 10;
	localparam logic [DIM_W-1:0] DIM_MAX   = 11'd1024;
	localparam logic [DIM_W-1:0] DIM_RESET = 11'd64;

	// Texture width over eight, wide enough for a 4096 texel texture
	localparam int unsigned TW8_W  = 10;
	localparam int unsigned ADDR_W = 20;
	localparam int unsigned PIX_W  = 32;

	// Register map, indexed by paddr[2]
	typedef enum logic {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} tts_reg_t;

	// Image geometry handed from the register block to the pixel pipeline
	typedef struct packed {
		logic [CNT_W-1:0] w_m1;   // effective width minus one
		logic [CNT_W-1:0] h_m1;   // effective height minus one
		logic [TW8_W-1:0] tw8;    // texture width / 8
	} tts_geom_t;

	// Clamp a raw size to 1..1024 and return it minus one
	function automatic logic [CNT_W-1:0] eff_m1(input logic [DIM_W-1:0] v);
		logic [CNT_W-1:0] r;
		if (v == '0) begin
			r = '0;
		end else if (v > DIM_MAX) begin
			r = '1;
		end else begin
			r = CNT_W'(v - DIM_W'(1));
		end
		return r;
	endfunction

	// Next power of two at or above (m1 + 1)
	function automatic logic [DIM_W-1:0] ceil_pow2(input logic [CNT_W-1:0] m1);
		logic [DIM_W-1:0] p;
		p = DIM_W'(1);
		for (int i = 0; i < CNT_W; i++) begin
			if (m1[i]) begin
				p = DIM_W'(2) << i;
			end
		end
		return p;
	endfunction

	// ABGR from RGBA: plain byte reversal
	function automatic logic [PIX_W-1:0] to_abgr(input logic [PIX_W-1:0] px);
		return {px[7:0], px[15:8], px[23:16], px[31:24]};
	endfunction

endpackage

[src/tts_cfg.sv]
module tts_cfg #(
	parameter int unsigned MIN_TEX_DIM = 64,
	parameter int unsigned MAX_TEX_DIM = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output tts_pkg::tts_geom_t  geom
);
	import tts_pkg::*;

	localparam int unsigned TWF_W = 13;

	// Texture width over eight, after clamping to the texture size bounds
	function automatic logic [TW8_W-1:0] tex_div8(input logic [CNT_W-1:0] m1);
		logic [TWF_W-1:0] tw;
		tw = TWF_W'(ceil_pow2(m1));
		if (tw < TWF_W'(MIN_TEX_DIM)) begin
			tw = TWF_W'(MIN_TEX_DIM);
		end
		if (tw > TWF_W'(MAX_TEX_DIM)) begin
			tw = TWF_W'(MAX_TEX_DIM);
		end
		return tw[TWF_W-1:3];
	endfunction

	logic [DIM_W-1:0] width_q, height_q;
	logic [CNT_W-1:0] w_m1_q, h_m1_q;
	logic [TW8_W-1:0] tw8_q;
	logic             wr;
	tts_reg_t         idx;
	logic [DIM_W-1:0] wdat;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;
	assign idx    = tts_reg_t'(paddr[2]);
	assign wdat   = pwdata[DIM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
			w_m1_q   <= eff_m1(DIM_RESET);
			h_m1_q   <= eff_m1(DIM_RESET);
			tw8_q    <= tex_div8(eff_m1(DIM_RESET));
		end else if (wr) begin
			case (idx)
				REG_IMAGE_WIDTH: begin
					width_q <= wdat;
					w_m1_q  <= eff_m1(wdat);
					tw8_q   <= tex_div8(eff_m1(wdat));
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= wdat;
					h_m1_q   <= eff_m1(wdat);
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_IMAGE_WIDTH:  prdata = 32'(width_q);
			REG_IMAGE_HEIGHT: prdata = 32'(height_q);
			default:          prdata = '0;
		endcase
	end

	assign geom.w_m1 = w_m1_q;
	assign geom.h_m1 = h_m1_q;
	assign geom.tw8  = tw8_q;

endmodule

[src/tts_pipe.sv]
module tts_pipe (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tts_pkg::tts_geom_t            geom,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [tts_pkg::PIX_W-1:0]     pixel_rgba,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tts_pkg::ADDR_W-1:0]    dest_word_address,
	output logic [tts_pkg::PIX_W-1:0]     pixel_abgr,
	output logic                          last_pixel
);
	import tts_pkg::*;

	localparam int unsigned PROD_W = (CNT_W - 3) + TW8_W;
	localparam int unsigned TILE_W = PROD_W + 1;
	localparam int unsigned FULL_W = TILE_W + 6;

	logic [CNT_W-1:0]  col_q, row_q;
	logic              adv_s1, adv_s2, accept;
	logic              row_end, img_end;

	logic              valid_s1;
	logic [CNT_W-1:0]  x_s1, y_s1;
	logic [PIX_W-1:0]  rgba_s1;
	logic              last_s1;

	logic              valid_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic [PIX_W-1:0]  abgr_s2;
	logic              last_s2;

	logic [PROD_W-1:0] prod;
	logic [TILE_W-1:0] tile;
	logic [5:0]        morton;
	logic [FULL_W-1:0] addr_full;

	// Flow control: a stage moves when the one after it has room
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;
	assign accept   = in_valid && adv_s1;

	assign row_end = (col_q >= geom.w_m1);
	assign img_end = row_end && (row_q >= geom.h_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= img_end ? '0 : row_q + CNT_W'(1);
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end

	// Tile row * tiles per row + tile column, then Z order inside the tile
	assign prod      = PROD_W'(y_s1[CNT_W-1:3]) * PROD_W'(geom.tw8);
	assign tile      = TILE_W'(prod) + TILE_W'(x_s1[CNT_W-1:3]);
	assign morton    = {y_s1[2], x_s1[2], y_s1[1], x_s1[1], y_s1[0], x_s1[0]};
	assign addr_full = {tile, morton};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1    <= col_q;
			y_s1    <= row_q;
			rgba_s1 <= pixel_rgba;
			last_s1 <= img_end;
		end
		if (adv_s2 && valid_s1) begin
			addr_s2 <= addr_full[ADDR_W-1:0];
			abgr_s2 <= to_abgr(rgba_s1);
			last_s2 <= last_s1;
		end
	end

	assign out_valid         = valid_s2;
	assign dest_word_address = addr_s2;
	assign pixel_abgr        = abgr_s2;
	assign last_pixel        = last_s2;

	a_wrap_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		accept && img_end |=> col_q == '0 && row_q == '0)
		else $error("counters did not wrap after the last pixel");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s2 |=> valid_s1 && $stable(x_s1) && $stable(y_s1))
		else $error("blocked item in stage one was overwritten");

	a_count_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(col_q) && $stable(row_q))
		else $error("position counters moved without an accepted item");

endmodule

[src/tiled_texture_swizzle_writer.sv]
// Tiled texture swizzle writer.
// Input channel: one RGBA pixel per item (pixel_rgba), raster order, handshake
// in_valid / in_stall. Output channel: one item per pixel with the word address
// in an 8x8-tiled, Z-ordered texture, the pixel as ABGR, and last_pixel on the
// final pixel of the image; handshake out_valid / out_stall.
// Config: APB-style port, image_width at 0x0, image_height at 0x4 (11 bits
// each, reset 64). Write sizes only while the block is idle.
// An accepted item passes the stage one register, then the output register.
// Throughput: one pixel per cycle. The two pipeline registers plus the stall
// chain let a new item in every cycle while out_stall is low; the address path
// is one 7x10 multiply and an add between the stage one and output registers.
// When the receiver stalls, the output item holds and stage one still fills;
// in_stall rises only when both stages hold an item.
// Reset: sizes return to 64x64, column and row counters to zero, both pipeline
// stages empty.
module tiled_texture_swizzle_writer #(
	parameter int unsigned MIN_TEX_DIM = 64,
	parameter int unsigned MAX_TEX_DIM = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [2:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [tts_pkg::PIX_W-1:0]  pixel_rgba,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [tts_pkg::ADDR_W-1:0] dest_word_address,
	output logic [tts_pkg::PIX_W-1:0]  pixel_abgr,
	output logic                       last_pixel
);
	import tts_pkg::*;

	tts_geom_t geom;

	// Register block: keeps raw sizes for readback and the derived geometry
	tts_cfg #(
		.MIN_TEX_DIM (MIN_TEX_DIM),
		.MAX_TEX_DIM (MAX_TEX_DIM)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.geom    (geom)
	);

	// Counters, stage one register, address logic and output register
	tts_pipe u_pipe (
		.clk               (clk),
		.arst_n            (arst_n),
		.geom              (geom),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.pixel_rgba        (pixel_rgba),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.dest_word_address (dest_word_address),
		.pixel_abgr        (pixel_abgr),
		.last_pixel        (last_pixel)
	);

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import tts_pkg::*;

	localparam int unsigned MIN_TEX    = 64;
	localparam int unsigned MAX_TEX    = 1024;
	localparam int unsigned PIXEL_GOAL = 1650;  // stop adding size phases past this
	localparam int unsigned LONG_HOLD  = 180;   // one long receiver hold-off, in cycles
	localparam int unsigned QUIET_MAX  = 4000;  // cycles with no handshake before giving up
	localparam int unsigned TAIL_WAIT  = 8;     // pipeline is two deep; spare wait at the end
	localparam int DIRECTED_ROWS = 25;

	// One output item: tiled address, swizzled pixel, end of image flag
	typedef struct packed {
		logic [ADDR_W-1:0] word_addr;
		logic [PIX_W-1:0]  abgr;
		logic              is_last;
	} texel_t;

	// Hand-typed expectation for a directed pixel; typed == 0 defers to the predictor
	typedef struct packed {
		logic   typed;
		texel_t texel;
	} known_texel_t;

	// Directed row: either a size register write or one pixel
	typedef struct packed {
		logic      is_write;
		tts_reg_t  reg_sel;
		logic [31:0] data;
		logic      typed;
		texel_t    texel;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [2:0]        paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [PIX_W-1:0]  pixel_rgba = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [ADDR_W-1:0] dest_word_address;
	logic [PIX_W-1:0]  pixel_abgr;
	logic              last_pixel;

	tiled_texture_swizzle_writer #(
		.MIN_TEX_DIM(MIN_TEX),
		.MAX_TEX_DIM(MAX_TEX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel_rgba(pixel_rgba),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.dest_word_address(dest_word_address),
		.pixel_abgr(pixel_abgr),
		.last_pixel(last_pixel)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor state: its own copy of the size registers and counters
	// ------------------------------------------------------------------
	logic [DIM_W-1:0] img_width  = 11'd64;
	logic [DIM_W-1:0] img_height = 11'd64;
	logic [CNT_W-1:0] col_count  = '0;
	logic [CNT_W-1:0] row_count  = '0;

	texel_t       pending_texels[$];  // expected output items, oldest first
	known_texel_t known_texels[$];    // typed expectations for the directed pixels

	int unsigned pixels_sent     = 0;
	int unsigned pixels_accepted = 0;
	int unsigned results_seen    = 0;
	int unsigned images_closed   = 0;
	int unsigned size_writes     = 0;
	int unsigned size_phases     = 0;
	int unsigned mismatches      = 0;
	int unsigned quiet_cycles    = 0;
	int unsigned burst_left      = 0;
	int unsigned max_addr_seen   = 0;
	bit          long_hold_done  = 1'b0;

	// Size register as the block sees it: 0 acts as 1, anything over 1024 as 1024
	function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] raw);
		if (raw == '0)
			return 1;
		if (raw > 11'd1024)
			return 1024;
		return 32'(raw);
	endfunction

	// Image width rounded up to a power of two, held inside the texture limits
	function automatic int unsigned texture_width(input int unsigned w);
		int unsigned p = 1;
		while (p < w)
			p = p << 1;
		if (p < MIN_TEX)
			p = MIN_TEX;
		if (p > MAX_TEX)
			p = MAX_TEX;
		return p;
	endfunction

	// Z order inside an 8x8 tile: x0 y0 x1 y1 x2 y2 from bit 0 up
	function automatic logic [5:0] z_order8(input logic [2:0] x, input logic [2:0] y);
		return {y[2], x[2], y[1], x[1], y[0], x[0]};
	endfunction

	// Where this pixel lands, then advance the raster counters
	function automatic texel_t place_texel(input logic [PIX_W-1:0] px);
		int unsigned w;
		int unsigned h;
		int unsigned tw;
		int unsigned x;
		int unsigned y;
		int unsigned tile;
		texel_t t;
		w = clamp_dim(img_width);
		h = clamp_dim(img_height);
		tw = texture_width(w);
		x = 32'(col_count);
		y = 32'(row_count);
		tile = (y >> 3) * (tw >> 3) + (x >> 3);
		t.word_addr = ADDR_W'((tile << 6) + z_order8(x[2:0], y[2:0]));
		t.abgr = {px[7:0], px[15:8], px[23:16], px[31:24]};
		t.is_last = 1'b0;
		if (x >= w - 1) begin
			col_count = '0;
			if (y >= h - 1) begin
				row_count = '0;
				t.is_last = 1'b1;
			end else begin
				row_count = CNT_W'(y + 1);
			end
		end else begin
			col_count = CNT_W'(x + 1);
		end
		return t;
	endfunction

	// ------------------------------------------------------------------
	// Monitor: everything is sampled at the rising edge, before the
	// nonblocking updates of that edge land, so no ordering races.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		texel_t want;
		known_texel_t hint;
		if (arst_n) begin
			// register writes update the predictor's copy at the access edge
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_IMAGE_HEIGHT)
					img_height = pwdata[DIM_W-1:0];
				else
					img_width = pwdata[DIM_W-1:0];
				size_writes++;
			end

			if (in_valid && !in_stall) begin
				want = place_texel(pixel_rgba);
				// directed pixels may carry a hand-typed answer instead
				if (known_texels.size() != 0) begin
					hint = known_texels.pop_front();
					if (hint.typed)
						want = hint.texel;
				end
				pending_texels = {pending_texels, want};
				pixels_accepted++;
			end

			if (out_valid && !out_stall) begin
				results_seen++;
				if (pending_texels.size() == 0) begin
					$error("unexpected output item: addr %h abgr %h last %b",
						dest_word_address, pixel_abgr, last_pixel);
					mismatches++;
				end else begin
					want = pending_texels.pop_front();
					if (dest_word_address !== want.word_addr) begin
						$error("dest_word_address: expected %h, actual %h",
							want.word_addr, dest_word_address);
						mismatches++;
					end
					if (pixel_abgr !== want.abgr) begin
						$error("pixel_abgr: expected %h, actual %h", want.abgr, pixel_abgr);
						mismatches++;
					end
					if (last_pixel !== want.is_last) begin
						$error("last_pixel: expected %b, actual %b", want.is_last, last_pixel);
						mismatches++;
					end
				end
				if (last_pixel === 1'b1)
					images_closed++;
				if (32'(dest_word_address) > max_addr_seen)
					max_addr_seen = 32'(dest_word_address);
			end
		end
	end

	// Watchdog: any handshake or register access counts as progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_MAX) begin
					$display("timeout: no handshake for %0d cycles", QUIET_MAX);
					$display("testbench failed");
					$finish;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: stretches of free flow and stretches of random stalls,
	// plus one long hold-off once the stream is well underway so the
	// two pipeline stages fill and in_stall has to rise.
	// ------------------------------------------------------------------
	initial begin
		int unsigned stretch;
		int unsigned busy;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (!long_hold_done && pixels_accepted >= 400) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_done = 1'b1;
			end
			stretch = $urandom_range(10, 120);
			busy = $urandom_range(0, 3);  // 0: never stall, else stall busy/4 of the time
			repeat (stretch) begin
				out_stall <= (busy != 0) && ($urandom_range(0, 3) < busy);
				@(posedge clk);
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------

	// Offer one pixel and return at the edge that takes it. Bursts of random
	// length with random gaps; valid stays high across a burst.
	task automatic send_pixel(input logic [PIX_W-1:0] px);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		in_valid <= 1'b1;
		pixel_rgba <= px;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		burst_left--;
		pixels_sent++;
	endtask

	// Drop valid and wait until every pixel sent has come out again
	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (results_seen < pixels_sent)
			@(posedge clk);
	endtask

	// APB write (setup + access) followed by a read back of the same register,
	// then psel drops so a following access starts on a fresh edge
	task automatic write_size(input tts_reg_t which, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {which, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== {21'd0, value[DIM_W-1:0]}) begin
			$error("prdata: expected %h, actual %h", {21'd0, value[DIM_W-1:0]}, prdata);
			mismatches++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Random size: mostly small so rows and images close often, with zero,
	// oversize, exactly 1024 and mid-range sizes mixed in
	function automatic logic [DIM_W-1:0] pick_size();
		int unsigned pick;
		pick = $urandom_range(0, 15);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return DIM_W'($urandom_range(1025, 2047));
		if (pick == 2)
			return DIM_W'($urandom_range(65, 1024));
		if (pick == 3)
			return 11'd1024;
		return DIM_W'($urandom_range(1, 24));
	endfunction

	// Directed rows. Typed answers follow the counters from reset:
	//  - 64x64 after reset: x steps 0,1,2 -> addresses 0,1,4
	//  - width dropped to 1 with x already at 3: x beyond the row end, wraps
	//  - height 1 with y at 1: beyond the image end, closes the image
	//  - width/height of 0 act as 1; 2047 and 1025 act as 1024
	//  - upper pwdata bits are ignored by the 11-bit registers
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{1'b0, REG_IMAGE_WIDTH,  32'h1122_3344, 1'b1, '{20'd0, 32'h4433_2211, 1'b0}},
		'{1'b0, REG_IMAGE_WIDTH,  32'hFFFF_FFFF, 1'b1, '{20'd1, 32'hFFFF_FFFF, 1'b0}},
		'{1'b0, REG_IMAGE_WIDTH,  32'h0000_0000, 1'b1, '{20'd4, 32'h0000_0000, 1'b0}},
		'{1'b1, REG_IMAGE_WIDTH,  32'hFFFF_F801, 1'b0, '0},
		'{1'b0, REG_IMAGE_WIDTH,  32'h8000_0001, 1'b1, '{20'd5, 32'h0100_0080, 1'b0}},
		'{1'b1, REG_IMAGE_HEIGHT, 32'h0000_0001, 1'b0, '0},
		'{1'b0, REG_IMAGE_WIDTH,  32'h0000_FF00, 1'b1, '{20'd2, 32'h00FF_0000, 1'b1}},
		'{1'b0, REG_IMAGE_WIDTH,  32'h1234_5678, 1'b1, '{20'd0, 32'h7856_3412, 1'b1}},
		'{1'b1, REG_IMAGE_WIDTH,  32'h0000_0000, 1'b0, '0},
		'{1'b1, REG_IMAGE_HEIGHT, 32'h0000_0000, 1'b0, '0},
		'{1'b0, REG_IMAGE_WIDTH,  32'hA5A5_A5A5, 1'b1, '{20'd0, 32'hA5A5_A5A5, 1'b1}},
		'{1'b1, REG_IMAGE_WIDTH,  32'h0000_07FF, 1'b0, '0},
		'{1'b1, REG_IMAGE_HEIGHT, 32'h0000_0401, 1'b0, '0},
		'{1'b0, REG_IMAGE_WIDTH,  32'h5A5A_5A5A, 1'b1, '{20'd0, 32'h5A5A_5A5A, 1'b0}},
		'{1'b0, REG_IMAGE_WIDTH,  32'hDEAD_BEEF, 1'b1, '{20'd1, 32'hEFBE_ADDE, 1'b0}},
		'{1'b1, REG_IMAGE_WIDTH,  32'h0000_0400, 1'b0, '0},
		'{1'b1, REG_IMAGE_HEIGHT, 32'h0000_0003, 1'b0, '0},
		'{1'b0, REG_IMAGE_WIDTH,  32'h0F0F_0F0F, 1'b0, '0},
		'{1'b1, REG_IMAGE_WIDTH,  32'h0000_0003, 1'b0, '0},
		'{1'b0, REG_IMAGE_WIDTH,  32'hF0F0_F0F0, 1'b0, '0},
		'{1'b0, REG_IMAGE_WIDTH,  32'h0123_4567, 1'b0, '0},
		'{1'b0, REG_IMAGE_WIDTH,  32'h89AB_CDEF, 1'b0, '0},
		'{1'b0, REG_IMAGE_WIDTH,  32'h7FFF_FFFF, 1'b0, '0},
		'{1'b0, REG_IMAGE_WIDTH,  32'h8000_0000, 1'b0, '0},
		'{1'b0, REG_IMAGE_WIDTH,  32'hFEDC_BA98, 1'b0, '0}
	};

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int unsigned count;
		logic [31:0] value;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; size writes only once the pipeline has drained
		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_write) begin
				wait_idle();
				write_size(directed_rows[i].reg_sel, directed_rows[i].data);
			end else begin
				known_texels = {known_texels,
					known_texel_t'{directed_rows[i].typed, directed_rows[i].texel}};
				send_pixel(directed_rows[i].data);
			end
		end

		// Tall phase: one pixel per row walks y close to 1023
		wait_idle();
		write_size(REG_IMAGE_WIDTH, 32'd1);
		write_size(REG_IMAGE_HEIGHT, 32'd1024);
		count = 1010 + $urandom_range(0, 12);
		repeat (count) send_pixel($urandom);

		// Widen to 1024 with the counters kept
		wait_idle();
		write_size(REG_IMAGE_WIDTH, 32'h0000_07FF);
		repeat (48) send_pixel($urandom);
		size_phases = 2;

		// Random size phases until the pixel budget is spent
		while (pixels_sent < PIXEL_GOAL) begin
			wait_idle();
			value = $urandom;
			value[DIM_W-1:0] = pick_size();
			write_size(REG_IMAGE_WIDTH, value);
			value = $urandom;
			value[DIM_W-1:0] = pick_size();
			write_size(REG_IMAGE_HEIGHT, value);
			count = $urandom_range(20, 120);
			repeat (count) send_pixel($urandom);
			size_phases++;
		end

		wait_idle();
		repeat (TAIL_WAIT) @(posedge clk);

		$display("%0d pixels through %0d size phases and %0d register writes",
			pixels_sent, size_phases, size_writes);
		$display("%0d images closed, highest address %h, long hold-off %s",
			images_closed, max_addr_seen, long_hold_done ? "done" : "missed");
		if (mismatches == 0 && pending_texels.size() == 0) begin
			$display("testbench passed");
		end else begin
			$display("%0d mismatches, %0d items still expected", mismatches,
				pending_texels.size());
			$display("testbench failed");
		end
		$finish;
	end

endmodule

[tiled_texture_swizzle_writer.f]
src/tts_pkg.sv
src/tts_cfg.sv
src/tts_pipe.sv
src/tiled_texture_swizzle_writer.sv
tb/testbench.sv
